@@ hw/rtl/bsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfb_pkg
// Types and constants shared by the byte-stuffed frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

	localparam logic [7:0] FLAG_BYTE     = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE   = 8'h7D;
	localparam logic [7:0] FLAG_SUBST    = 8'h5E;
	localparam logic [7:0] ESCAPE_SUBST  = 8'h5D;
	localparam logic [7:0] ADDRESS_RESET = 8'h03;
	localparam logic [7:0] CONTROL_SEQ0  = 8'h00;
	localparam logic [7:0] CONTROL_SEQ1  = 8'h40;

	// one classified payload byte, as queued between front and back
	typedef struct packed {
		logic       hdr;
		logic [7:0] addr;
		logic       seq;
		logic [7:0] data;
		logic [7:0] bcc;
		logic       last;
	} frame_cmd_t;

	typedef enum logic [8:0] {
		ST_FLAG  = 9'b000000001,
		ST_ADDR  = 9'b000000010,
		ST_CTRL  = 9'b000000100,
		ST_BCC1  = 9'b000001000,
		ST_DATA  = 9'b000010000,
		ST_DATA2 = 9'b000100000,
		ST_CHK   = 9'b001000000,
		ST_CHK2  = 9'b010000000,
		ST_CLOSE = 9'b100000000
	} step_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESCAPE_BYTE);
	endfunction

	function automatic logic [7:0] escape_subst(input logic [7:0] b);
		return (b == FLAG_BYTE) ? FLAG_SUBST : ESCAPE_SUBST;
	endfunction

endpackage

@@ hw/rtl/bsfb_front.sv @@
// ----------------------------------------------------------------------------
// bsfb_front
// Accepts payload bytes, tracks frame state and running check, and builds
// one queued command per byte.
// ----------------------------------------------------------------------------
module bsfb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 address_we,
	input  logic [7:0]           address_byte,
	input  logic                 push,
	input  logic                 q_full,
	input  logic [7:0]           data_byte,
	input  logic                 seq_bit,
	input  logic                 last_byte,
	output logic                 q_wr,
	output bsfb_pkg::frame_cmd_t q_cmd
);
	import bsfb_pkg::*;

	logic       in_frame_q;
	logic [7:0] check_q;
	logic [7:0] address_q;
	logic [7:0] bcc;

	assign q_wr = push && !q_full;
	assign bcc  = (in_frame_q ? check_q : 8'h00) ^ data_byte;

	always_comb begin
		q_cmd.hdr  = !in_frame_q;
		q_cmd.addr = address_q;
		q_cmd.seq  = seq_bit;
		q_cmd.data = data_byte;
		q_cmd.bcc  = bcc;
		q_cmd.last = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			check_q    <= 8'h00;
			address_q  <= ADDRESS_RESET;
		end else begin
			if (address_we) begin
				address_q <= address_byte;
			end
			if (q_wr) begin
				in_frame_q <= !last_byte;
				check_q    <= last_byte ? 8'h00 : bcc;
			end
		end
	end

endmodule

@@ hw/rtl/bsfb_queue.sv @@
// ----------------------------------------------------------------------------
// bsfb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bsfb_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  bsfb_pkg::frame_cmd_t wr_cmd,
	input  logic                 rd,
	output bsfb_pkg::frame_cmd_t rd_cmd,
	output logic                 full,
	output logic                 empty
);
	import bsfb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	frame_cmd_t    mem [DEPTH];
	frame_cmd_t    rd_cmd_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] rd_ptr_nxt;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign rd_cmd     = rd_cmd_q;
	assign rd_ptr_nxt = rd ? ((rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;

	// head entry held in a register, with the incoming transaction passed through
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
		if (wr && (wr_ptr_q == rd_ptr_nxt)) begin
			rd_cmd_q <= wr_cmd;
		end else begin
			rd_cmd_q <= mem[rd_ptr_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			rd_ptr_q <= rd_ptr_nxt;
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/bsfb_back.sv @@
// ----------------------------------------------------------------------------
// bsfb_back
// Per queued command, emits header at frame start, stuffed data, check and
// closing flag at end; one byte per cycle into the output register when free.
// ----------------------------------------------------------------------------
module bsfb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  bsfb_pkg::frame_cmd_t q_cmd,
	output logic                 q_rd,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           line_byte,
	output logic                 run_end,
	output logic                 frame_end
);
	import bsfb_pkg::*;

	step_t      step_q;
	logic       start_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       orun_q;
	logic       oend_q;

	step_t      cur;
	step_t      nxt;
	logic [7:0] b;
	logic       done;
	logic       adv;
	logic [7:0] ctrl;

	assign ctrl = q_cmd.seq ? CONTROL_SEQ1 : CONTROL_SEQ0;
	assign adv  = !q_empty && (!ovalid_q || pop);
	assign q_rd = adv && done;

	always_comb begin
		cur  = start_q ? (q_cmd.hdr ? ST_FLAG : ST_DATA) : step_q;
		nxt  = ST_FLAG;
		b    = FLAG_BYTE;
		done = 1'b0;
		case (cur)
			ST_FLAG: begin
				b   = FLAG_BYTE;
				nxt = ST_ADDR;
			end
			ST_ADDR: begin
				b   = q_cmd.addr;
				nxt = ST_CTRL;
			end
			ST_CTRL: begin
				b   = ctrl;
				nxt = ST_BCC1;
			end
			ST_BCC1: begin
				b   = q_cmd.addr ^ ctrl;
				nxt = ST_DATA;
			end
			ST_DATA: begin
				if (needs_escape(q_cmd.data)) begin
					b   = ESCAPE_BYTE;
					nxt = ST_DATA2;
				end else begin
					b    = q_cmd.data;
					nxt  = ST_CHK;
					done = !q_cmd.last;
				end
			end
			ST_DATA2: begin
				b    = escape_subst(q_cmd.data);
				nxt  = ST_CHK;
				done = !q_cmd.last;
			end
			ST_CHK: begin
				if (needs_escape(q_cmd.bcc)) begin
					b   = ESCAPE_BYTE;
					nxt = ST_CHK2;
				end else begin
					b   = q_cmd.bcc;
					nxt = ST_CLOSE;
				end
			end
			ST_CHK2: begin
				b   = escape_subst(q_cmd.bcc);
				nxt = ST_CLOSE;
			end
			ST_CLOSE: begin
				b    = FLAG_BYTE;
				done = 1'b1;
			end
			default: begin
				b    = FLAG_BYTE;
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_FLAG;
			start_q  <= 1'b1;
			ovalid_q <= 1'b0;
		end else begin
			if (adv) begin
				ovalid_q <= 1'b1;
				start_q  <= done;
				step_q   <= nxt;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			obyte_q <= b;
			orun_q  <= done;
			oend_q  <= (cur == ST_CLOSE);
		end
	end

	assign empty     = !ovalid_q;
	assign line_byte = obyte_q;
	assign run_end   = orun_q;
	assign frame_end = oend_q;

endmodule

@@ hw/rtl/byte_stuffed_frame_builder.sv @@
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder
// HDLC-style framer: header, byte-stuffed payload, XOR check, closing flag.
// ----------------------------------------------------------------------------
// Payload bytes are pushed one per transaction and classified by the front
// part, which keeps the frame state and running check and samples the address
// register at the first byte of a frame. The back part emits one line byte per
// cycle unless its output register waits unpopped. Per payload byte it emits
// one or two for a plain or escaped byte, plus four for the header on the first
// byte and two to three for check and flag on the last, nine at most. The back
// sequencer's single byte per cycle sets the sustained rate; up to QUEUE_DEPTH
// classified bytes wait between the parts, and the result register lets a new
// byte be pushed while a line byte waits to be popped. No clearing pass.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_builder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       address_we,
	input  logic [7:0] address_byte,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       seq_bit,
	input  logic       last_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] line_byte,
	output logic       run_end,
	output logic       frame_end
);
	import bsfb_pkg::*;

	frame_cmd_t wr_cmd;
	frame_cmd_t rd_cmd;
	logic       q_wr;
	logic       q_rd;
	logic       q_empty;

	bsfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.address_we   (address_we),
		.address_byte (address_byte),
		.push         (push),
		.q_full       (full),
		.data_byte    (data_byte),
		.seq_bit      (seq_bit),
		.last_byte    (last_byte),
		.q_wr         (q_wr),
		.q_cmd        (wr_cmd)
	);

	bsfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_cmd (wr_cmd),
		.rd     (q_rd),
		.rd_cmd (rd_cmd),
		.full   (full),
		.empty  (q_empty)
	);

	bsfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (rd_cmd),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.line_byte (line_byte),
		.run_end   (run_end),
		.frame_end (frame_end)
	);

endmodule

@@ hw/rtl/bsfb_checker.sv @@
// ----------------------------------------------------------------------------
// bsfb_checker
// Port-level checks on the framer's result stream.
// ----------------------------------------------------------------------------
module bsfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] line_byte,
	input logic       run_end,
	input logic       frame_end
);
	import bsfb_pkg::*;

	// closing flag ends the run of its payload byte
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> run_end)
		else $error("closing flag without run end");

	// closing flag carries the flag value
	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> (line_byte == FLAG_BYTE))
		else $error("closing flag value wrong");

	// a closed frame is followed by the opening flag of the next
	a_next_open: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && frame_end) |=> (empty || (line_byte == FLAG_BYTE)))
		else $error("frame not opened by flag");

	// waiting line byte holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(line_byte) && $stable(run_end)))
		else $error("result changed while waiting");

endmodule

bind byte_stuffed_frame_builder bsfb_checker u_bsfb_checker (.*);
